/* hdl/rei_pkg.sv */
// ----------------------------------------------------------------------------
// rei_pkg
// Shared widths, types, register codes and saturation helpers of the
// ray / ellipsoid intersection core.
// ----------------------------------------------------------------------------
package rei_pkg;

	localparam int CW     = 32;
	localparam int FB     = 16;
	localparam int KW     = CW - 1;
	localparam int PW     = CW + 1;
	localparam int MW     = 2 * PW;
	localparam int SPLIT  = CW;
	localparam int HW     = MW - SPLIT;
	localparam int TW     = MW + KW + 1;
	localparam int SW     = TW + 2;
	localparam int AW     = 64;
	localparam int HALF   = AW / 2;
	localparam int DW     = 2 * AW;
	localparam int RTW    = AW;
	localparam int RMW    = RTW + 4;
	localparam int VW     = AW + 3;
	localparam int NW     = VW - 1 + FB;
	localparam int CMPW   = (NW > AW ? NW : AW) + 1;
	localparam int PRW    = CW + KW + 1;
	localparam int NMW    = PW + KW + 1;
	localparam int CLW    = 2 * CW + 2;
	localparam int CFG_IW = 3;
	localparam int Q_DEPTH = 4;
	localparam int QAW    = $clog2(Q_DEPTH);

	localparam int     EPS_Q    = ((1 << FB) + 500) / 1000;
	localparam longint DISC_MIN = ((longint'(EPS_Q) << FB) + 3) >> 2;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [KW-1:0]        kinv_t;
	typedef logic [KW-1:0]        dist_t;
	typedef logic signed [AW-1:0] coef_t;
	typedef logic [DW-1:0]        disc_t;

	localparam coef_t  COEF_MAX  = {1'b0, {(AW-1){1'b1}}};
	localparam coef_t  COEF_MIN  = {1'b1, {(AW-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam dist_t  DIST_MAX  = '1;
	localparam logic signed [SW-1:0] Q3_ONE   = {{(SW-1){1'b0}}, 1'b1} << (3 * FB);
	localparam logic signed [DW:0]   DISC_LIM = (DW+1)'(DISC_MIN);

	typedef enum logic [CFG_IW-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_INV_X_SQ = 3'd3,
		REG_INV_Y_SQ = 3'd4,
		REG_INV_Z_SQ = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		coord_t [2:0] o;
		coord_t [2:0] d;
	} ray_t;

	typedef struct packed {
		coord_t [2:0] ce;
		kinv_t  [2:0] k;
	} geom_t;

	typedef struct packed {
		logic  miss;
		coef_t a;
		coef_t h;
		disc_t disc;
		ray_t  ray;
	} job_t;

	typedef struct packed {
		logic  miss;
		coef_t a;
		coef_t h;
		ray_t  ray;
	} side_t;

	function automatic coef_t sat_coef(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] y;
		y = x >>> (2 * FB);
		if (&y[SW-1:AW-1] || !(|y[SW-1:AW-1]))
			return coef_t'(y[AW-1:0]);
		return y[SW-1] ? COEF_MIN : COEF_MAX;
	endfunction

	function automatic coord_t clamp_coord(input logic signed [CLW-1:0] v);
		if (&v[CLW-1:CW-1] || !(|v[CLW-1:CW-1]))
			return coord_t'(v[CW-1:0]);
		return v[CLW-1] ? COORD_MIN : COORD_MAX;
	endfunction

endpackage

/* hdl/rei_ray_if.sv */
// ----------------------------------------------------------------------------
// rei_ray_if
// Ray channel: origin and direction beats with valid / ready.
// ----------------------------------------------------------------------------
interface rei_ray_if;
	import rei_pkg::*;
	logic   valid;
	logic   ready;
	coord_t origin_x;
	coord_t origin_y;
	coord_t origin_z;
	coord_t dir_x;
	coord_t dir_y;
	coord_t dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

/* hdl/rei_hit_if.sv */
// ----------------------------------------------------------------------------
// rei_hit_if
// Result channel: hit flag, distance, hit point and normal with valid / ready.
// ----------------------------------------------------------------------------
interface rei_hit_if;
	import rei_pkg::*;
	logic   valid;
	logic   ready;
	logic   hit;
	dist_t  distance;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	coord_t normal_x;
	coord_t normal_y;
	coord_t normal_z;

	modport source (output valid, hit, distance, point_x, point_y, point_z,
		normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, hit, distance, point_x, point_y, point_z,
		normal_x, normal_y, normal_z, output ready);
endinterface

/* hdl/rei_front.sv */
// ----------------------------------------------------------------------------
// rei_front
// Quadric coefficients a, h, c, the discriminant and the miss check,
// eleven pipeline stages feeding the job queue.
// ----------------------------------------------------------------------------
module rei_front (
	input  logic           clk,
	input  logic           arst_n,
	input  rei_pkg::geom_t geom,
	rei_ray_if.sink        ray,
	input  logic           q_full,
	output logic           push,
	output rei_pkg::job_t  job
);
	import rei_pkg::*;

	logic [11:1]          vld_q;
	logic                 en;
	ray_t                 ray_in;
	ray_t                 ray_s [1:11];
	logic signed [PW-1:0] p_s1 [3];
	logic signed [MW-1:0] m_s2 [9];
	logic [SPLIT+KW-1:0]  pl_s3 [9];
	logic signed [HW+KW:0] ph_s3 [9];
	logic signed [TW-1:0] t_s4 [9];
	logic signed [SW-1:0] sum_s5 [3];
	coef_t                a_s [6:11];
	coef_t                h_s [6:11];
	coef_t                c_s6;
	logic [AW-1:0]        hm_s7, cm_s7;
	logic                 cneg_s7, cneg_s8, cneg_s9;
	logic [AW-1:0]        hh_ll_s8, hh_lh_s8, hh_hh_s8;
	logic [AW-1:0]        ac_ll_s8, ac_lh_s8, ac_hl_s8, ac_hh_s8;
	logic [AW-1:0]        au_s7;
	logic [DW-1:0]        hh_s9, ac_s9;
	logic signed [DW:0]   d_s10;
	logic                 miss_s11;
	disc_t                disc_s11;

	assign en        = !vld_q[11] || !q_full;
	assign ray.ready = en;
	assign push      = vld_q[11] && !q_full;
	assign au_s7     = AW'(a_s[7]);

	always_comb begin
		ray_in.o[0] = ray.origin_x;
		ray_in.o[1] = ray.origin_y;
		ray_in.o[2] = ray.origin_z;
		ray_in.d[0] = ray.dir_x;
		ray_in.d[1] = ray.dir_y;
		ray_in.d[2] = ray.dir_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[10:1], ray.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s[1] <= ray_in;
			for (int s = 2; s <= 11; s++)
				ray_s[s] <= ray_s[s-1];
			for (int i = 0; i < 3; i++)
				p_s1[i] <= PW'($signed(ray_in.o[i])) - PW'($signed(geom.ce[i]));
			// products d*d, p*d, p*p
			for (int i = 0; i < 3; i++) begin
				m_s2[i]   <= MW'($signed(ray_s[1].d[i])) * MW'($signed(ray_s[1].d[i]));
				m_s2[3+i] <= MW'(p_s1[i]) * MW'($signed(ray_s[1].d[i]));
				m_s2[6+i] <= MW'(p_s1[i]) * MW'(p_s1[i]);
			end
			// scale by k in two partial products
			for (int t = 0; t < 3; t++) begin
				for (int i = 0; i < 3; i++) begin
					pl_s3[3*t+i] <= (SPLIT+KW)'(m_s2[3*t+i][SPLIT-1:0])
						* (SPLIT+KW)'(geom.k[i]);
					ph_s3[3*t+i] <= (HW+KW+1)'($signed(m_s2[3*t+i][MW-1:SPLIT]))
						* (HW+KW+1)'($signed({1'b0, geom.k[i]}));
				end
			end
			for (int j = 0; j < 9; j++)
				t_s4[j] <= (TW'(ph_s3[j]) <<< SPLIT) + $signed(TW'(pl_s3[j]));
			sum_s5[0] <= SW'(t_s4[0]) + SW'(t_s4[1]) + SW'(t_s4[2]);
			sum_s5[1] <= SW'(t_s4[3]) + SW'(t_s4[4]) + SW'(t_s4[5]);
			sum_s5[2] <= SW'(t_s4[6]) + SW'(t_s4[7]) + SW'(t_s4[8]) - Q3_ONE;
			a_s[6] <= sat_coef(sum_s5[0]);
			h_s[6] <= sat_coef(sum_s5[1]);
			c_s6   <= sat_coef(sum_s5[2]);
			for (int s = 7; s <= 11; s++) begin
				a_s[s] <= a_s[s-1];
				h_s[s] <= h_s[s-1];
			end
			// magnitudes for the discriminant products
			hm_s7   <= h_s[6][AW-1] ? AW'(-h_s[6]) : AW'(h_s[6]);
			cm_s7   <= c_s6[AW-1] ? AW'(-c_s6) : AW'(c_s6);
			cneg_s7 <= c_s6[AW-1];
			hh_ll_s8 <= AW'(hm_s7[HALF-1:0]) * AW'(hm_s7[HALF-1:0]);
			hh_lh_s8 <= AW'(hm_s7[HALF-1:0]) * AW'(hm_s7[AW-1:HALF]);
			hh_hh_s8 <= AW'(hm_s7[AW-1:HALF]) * AW'(hm_s7[AW-1:HALF]);
			ac_ll_s8 <= AW'(au_s7[HALF-1:0]) * AW'(cm_s7[HALF-1:0]);
			ac_lh_s8 <= AW'(au_s7[HALF-1:0]) * AW'(cm_s7[AW-1:HALF]);
			ac_hl_s8 <= AW'(au_s7[AW-1:HALF]) * AW'(cm_s7[HALF-1:0]);
			ac_hh_s8 <= AW'(au_s7[AW-1:HALF]) * AW'(cm_s7[AW-1:HALF]);
			cneg_s8  <= cneg_s7;
			hh_s9 <= (DW'(hh_hh_s8) << AW) + (DW'(hh_lh_s8) << (HALF + 1)) + DW'(hh_ll_s8);
			ac_s9 <= (DW'(ac_hh_s8) << AW) + ((DW'(ac_lh_s8) + DW'(ac_hl_s8)) << HALF)
				+ DW'(ac_ll_s8);
			cneg_s9 <= cneg_s8;
			d_s10 <= cneg_s9 ? $signed({1'b0, hh_s9}) + $signed({1'b0, ac_s9})
				: $signed({1'b0, hh_s9}) - $signed({1'b0, ac_s9});
			miss_s11 <= (a_s[10] <= 0) || (d_s10 < DISC_LIM);
			disc_s11 <= d_s10[DW-1:0];
		end
	end

	always_comb begin
		job.miss = miss_s11;
		job.a    = a_s[11];
		job.h    = h_s[11];
		job.disc = disc_s11;
		job.ray  = ray_s[11];
	end

endmodule

/* hdl/rei_queue.sv */
// ----------------------------------------------------------------------------
// rei_queue
// Short job queue between the coefficient front and the root back.
// ----------------------------------------------------------------------------
module rei_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rei_pkg::job_t wr_job,
	output logic          full,
	output logic          valid,
	output rei_pkg::job_t rd_job,
	input  logic          pop
);
	import rei_pkg::*;

	job_t           mem_q [Q_DEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full   = cnt_q == (QAW+1)'(Q_DEPTH);
	assign valid  = cnt_q != '0;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hdl/rei_back.sv */
// ----------------------------------------------------------------------------
// rei_back
// Pipelined square root, two divider lanes for the near and far roots,
// root selection, hit point, normal and the result register.
// ----------------------------------------------------------------------------
module rei_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rei_pkg::geom_t geom,
	input  logic           q_valid,
	input  rei_pkg::job_t  job,
	output logic           pop,
	rei_hit_if.source      res
);
	import rei_pkg::*;

	localparam int LB = RTW + KW + 8;

	logic [LB-1:0]        v_q;
	logic                 en;

	logic [RMW-1:0]       sq_rem [0:RTW];
	logic [RTW-1:0]       sq_root [0:RTW];
	disc_t                sq_bits [0:RTW];
	side_t                sq_side [0:RTW];
	logic [RMW-1:0]       sq_nr [RTW];
	logic [RMW-1:0]       sq_tr [RTW];
	logic                 sq_ge [RTW];

	logic signed [VW-1:0] lv_s0 [2];
	side_t                lv_side_s0;
	logic [NW-1:0]        nn [2];
	logic [AW-1:0]        a_u0;

	logic [AW-1:0]        dv_rem [2][0:KW];
	logic [KW-1:0]        dv_q [2][0:KW];
	logic [KW-1:0]        dv_bits [2][0:KW];
	logic                 dv_bad [2][0:KW];
	logic                 dv_sat [2][0:KW];
	side_t                dv_side [0:KW];
	logic [AW:0]          dv_r2 [2][KW];
	logic                 dv_ge [2][KW];

	logic                 near_ok, far_ok;
	dist_t                tv_s1, tv_s2, tv_s3, tv_s4;
	logic                 hit_s1, hit_s2, hit_s3, hit_s4;
	ray_t                 ray_s1, ray_s2;
	logic signed [PRW-1:0] prod_s2 [3];
	coord_t               x_s3 [3];
	coord_t               x_s4 [3];
	logic signed [NMW-1:0] nm_s4 [3];

	logic                 hit_q;
	dist_t                dist_q;
	coord_t               point_q [3];
	coord_t               normal_q [3];

	assign en        = !v_q[LB-1] || res.ready;
	assign pop       = en && q_valid;
	assign res.valid = v_q[LB-1];
	assign a_u0      = AW'(lv_side_s0.a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LB-2:0], q_valid};
		end
	end

	// square root, two bits of the radicand per stage
	always_comb begin
		for (int i = 0; i < RTW; i++) begin
			sq_nr[i] = {sq_rem[i][RMW-3:0], sq_bits[i][DW-1 -: 2]};
			sq_tr[i] = RMW'({sq_root[i], 2'b01});
			sq_ge[i] = sq_nr[i] >= sq_tr[i];
		end
	end

	// long division, one quotient bit per stage in each lane
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			nn[l] = {lv_s0[l][VW-2:0], {FB{1'b0}}};
			for (int j = 0; j < KW; j++) begin
				dv_r2[l][j] = {dv_rem[l][j], dv_bits[l][j][KW-1]};
				dv_ge[l][j] = dv_r2[l][j] >= {1'b0, AW'(dv_side[j].a)};
			end
		end
	end

	always_comb begin
		near_ok = !dv_bad[0][KW] && (dv_sat[0][KW] || dv_q[0][KW] >= KW'(EPS_Q));
		far_ok  = !dv_bad[1][KW] && (dv_sat[1][KW] || dv_q[1][KW] >= KW'(EPS_Q));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem[0]  <= '0;
			sq_root[0] <= '0;
			sq_bits[0] <= job.disc;
			sq_side[0] <= '{miss: job.miss, a: job.a, h: job.h, ray: job.ray};
			for (int i = 0; i < RTW; i++) begin
				sq_rem[i+1]  <= sq_ge[i] ? sq_nr[i] - sq_tr[i] : sq_nr[i];
				sq_root[i+1] <= {sq_root[i][RTW-2:0], sq_ge[i]};
				sq_bits[i+1] <= sq_bits[i] << 2;
				sq_side[i+1] <= sq_side[i];
			end

			// near and far numerators
			lv_s0[0]   <= -VW'(sq_side[RTW].h) - $signed({3'b000, sq_root[RTW]});
			lv_s0[1]   <= -VW'(sq_side[RTW].h) + $signed({3'b000, sq_root[RTW]});
			lv_side_s0 <= sq_side[RTW];

			dv_side[0] <= lv_side_s0;
			for (int l = 0; l < 2; l++) begin
				dv_rem[l][0]  <= AW'(nn[l] >> KW);
				dv_bits[l][0] <= nn[l][KW-1:0];
				dv_q[l][0]    <= '0;
				dv_bad[l][0]  <= lv_s0[l][VW-1];
				dv_sat[l][0]  <= CMPW'(nn[l] >> KW) >= CMPW'(a_u0);
				for (int j = 0; j < KW; j++) begin
					dv_rem[l][j+1]  <= dv_ge[l][j]
						? AW'(dv_r2[l][j] - {1'b0, AW'(dv_side[j].a)}) : AW'(dv_r2[l][j]);
					dv_q[l][j+1]    <= {dv_q[l][j][KW-2:0], dv_ge[l][j]};
					dv_bits[l][j+1] <= dv_bits[l][j] << 1;
					dv_bad[l][j+1]  <= dv_bad[l][j];
					dv_sat[l][j+1]  <= dv_sat[l][j];
				end
			end
			for (int j = 0; j < KW; j++)
				dv_side[j+1] <= dv_side[j];

			// root choice
			if (near_ok)
				tv_s1 <= dv_sat[0][KW] ? DIST_MAX : dv_q[0][KW];
			else
				tv_s1 <= dv_sat[1][KW] ? DIST_MAX : dv_q[1][KW];
			hit_s1 <= !dv_side[KW].miss && (near_ok || far_ok);
			ray_s1 <= dv_side[KW].ray;

			// hit point
			for (int i = 0; i < 3; i++)
				prod_s2[i] <= PRW'($signed(ray_s1.d[i])) * PRW'($signed({1'b0, tv_s1}));
			tv_s2  <= tv_s1;
			hit_s2 <= hit_s1;
			ray_s2 <= ray_s1;

			for (int i = 0; i < 3; i++)
				x_s3[i] <= clamp_coord(CLW'($signed(ray_s2.o[i])) + CLW'(prod_s2[i] >>> FB));
			tv_s3  <= tv_s2;
			hit_s3 <= hit_s2;

			// normal
			for (int i = 0; i < 3; i++)
				nm_s4[i] <= NMW'(PW'(x_s3[i]) - PW'($signed(geom.ce[i])))
					* NMW'($signed({1'b0, geom.k[i]}));
			x_s4   <= x_s3;
			tv_s4  <= tv_s3;
			hit_s4 <= hit_s3;

			hit_q  <= hit_s4;
			dist_q <= hit_s4 ? tv_s4 : '0;
			for (int i = 0; i < 3; i++) begin
				point_q[i]  <= hit_s4 ? x_s4[i] : '0;
				normal_q[i] <= hit_s4 ? clamp_coord(CLW'(nm_s4[i] >>> FB)) : '0;
			end
		end
	end

	assign res.hit      = hit_q;
	assign res.distance = dist_q;
	assign res.point_x  = point_q[0];
	assign res.point_y  = point_q[1];
	assign res.point_z  = point_q[2];
	assign res.normal_x = normal_q[0];
	assign res.normal_y = normal_q[1];
	assign res.normal_z = normal_q[2];

endmodule

/* hdl/ray_ellipsoid_intersection_core.sv */
// throughput: one ray per cycle when res.ready and a non-full queue allow it; the
// 64-stage square root and the two 31-stage divider lanes are fully pipelined, a
// 4-deep queue splits front and back
// reset: clears pipeline valids and queue, center to 0 and inverse axes to 1.0
// ----------------------------------------------------------------------------
// ray_ellipsoid_intersection_core
// Ray / axis-aligned ellipsoid intersection with configuration registers.
// ----------------------------------------------------------------------------
module ray_ellipsoid_intersection_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rei_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [rei_pkg::CW-1:0]      cfg_data,
	rei_ray_if.sink                     ray,
	rei_hit_if.source                   res
);
	import rei_pkg::*;

	coord_t ce_q [3];
	kinv_t  k_q [3];
	geom_t  geom;
	job_t   f_job, q_job;
	logic   push, q_full, q_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ce_q[i] <= '0;
				k_q[i]  <= KW'(1) << FB;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: ce_q[0] <= coord_t'(cfg_data);
				REG_CENTER_Y: ce_q[1] <= coord_t'(cfg_data);
				REG_CENTER_Z: ce_q[2] <= coord_t'(cfg_data);
				REG_INV_X_SQ: k_q[0]  <= cfg_data[KW-1:0];
				REG_INV_Y_SQ: k_q[1]  <= cfg_data[KW-1:0];
				REG_INV_Z_SQ: k_q[2]  <= cfg_data[KW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			geom.ce[i] = ce_q[i];
			geom.k[i]  = k_q[i];
		end
	end

	rei_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom),
		.ray    (ray),
		.q_full (q_full),
		.push   (push),
		.job    (f_job)
	);

	rei_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (f_job),
		.full   (q_full),
		.valid  (q_valid),
		.rd_job (q_job),
		.pop    (pop)
	);

	rei_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.q_valid (q_valid),
		.job     (q_job),
		.pop     (pop),
		.res     (res)
	);

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Ray / ellipsoid intersection core: directed rays at the reset and extreme
// geometries, then rounds of aimed, loose and full-range random rays under
// several geometries and idling mixes, each result beat checked in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rei_pkg::*;

	typedef logic signed [131:0] wide_t;

	typedef struct {
		coord_t o[3];
		coord_t d[3];
	} ray_beat_t;

	typedef struct {
		logic   hit;
		dist_t  distance;
		coord_t point[3];
		coord_t normal[3];
	} hit_beat_t;

	localparam int ONE = 1 << FB;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	rei_ray_if ray_ch();
	rei_hit_if hit_ch();

	ray_ellipsoid_intersection_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.ray(ray_ch),
		.res(hit_ch)
	);

	longint center[3];
	longint inv_sq[3];
	hit_beat_t expected_hits[$];
	int errors = 0;
	int send_idle = 26;
	int recv_idle = 79;
	longint cycles = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		ray_ch.valid = 1'b0;
		ray_ch.origin_x = '0;
		ray_ch.origin_y = '0;
		ray_ch.origin_z = '0;
		ray_ch.dir_x = '0;
		ray_ch.dir_y = '0;
		ray_ch.dir_z = '0;
		hit_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		hit_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	function automatic wide_t sat64(wide_t x);
		if (x > wide_t'(COEF_MAX))
			return wide_t'(COEF_MAX);
		if (x < wide_t'(COEF_MIN))
			return wide_t'(COEF_MIN);
		return x;
	endfunction

	function automatic coord_t clamp32(wide_t x);
		if (x > wide_t'(COORD_MAX))
			return COORD_MAX;
		if (x < wide_t'(COORD_MIN))
			return COORD_MIN;
		return coord_t'(x[CW-1:0]);
	endfunction

	function automatic wide_t floor_sqrt(wide_t v);
		wide_t r;
		wide_t c;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (wide_t'(1) <<< i);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic hit_beat_t predict_hit(ray_beat_t r);
		hit_beat_t res;
		wide_t sa, sh, sc, a, h, c, disc, s, t, x, oi, di, pi, ki, ci;
		sa = 0;
		sh = 0;
		sc = 0;
		res.hit = 1'b0;
		res.distance = '0;
		for (int i = 0; i < 3; i++) begin
			res.point[i] = '0;
			res.normal[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			oi = wide_t'(longint'(r.o[i]));
			di = wide_t'(longint'(r.d[i]));
			ki = wide_t'(inv_sq[i]);
			pi = oi - wide_t'(center[i]);
			sa = sa + ki * di * di;
			sh = sh + ki * pi * di;
			sc = sc + ki * pi * pi;
		end
		sc = sc - (wide_t'(1) <<< (3 * FB));
		a = sat64(sa >>> (2 * FB));
		h = sat64(sh >>> (2 * FB));
		c = sat64(sc >>> (2 * FB));
		if (a <= 0)
			return res;
		disc = h * h - a * c;
		if (disc < wide_t'(DISC_MIN))
			return res;
		s = floor_sqrt(disc);
		t = ((-h - s) <<< FB) / a;
		if (t < wide_t'(EPS_Q))
			t = ((-h + s) <<< FB) / a;
		if (t < wide_t'(EPS_Q))
			return res;
		if (t > wide_t'(DIST_MAX))
			t = wide_t'(DIST_MAX);
		res.hit = 1'b1;
		res.distance = dist_t'(t[KW-1:0]);
		for (int i = 0; i < 3; i++) begin
			oi = wide_t'(longint'(r.o[i]));
			di = wide_t'(longint'(r.d[i]));
			ci = wide_t'(center[i]);
			x = wide_t'(longint'(clamp32(sat64(oi + ((di * t) >>> FB)))));
			res.point[i] = coord_t'(x[CW-1:0]);
			res.normal[i] = clamp32(sat64(((x - ci) * wide_t'(inv_sq[i])) >>> FB));
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		hit_beat_t want;
		if (hit_ch.valid && hit_ch.ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected result beat", 0, 0);
			end else begin
				want = expected_hits.pop_front();
				if (hit_ch.hit !== want.hit)
					report_mismatch("hit", hit_ch.hit, want.hit);
				if (hit_ch.distance !== want.distance)
					report_mismatch("distance", hit_ch.distance, want.distance);
				if (hit_ch.point_x !== want.point[0])
					report_mismatch("point_x", hit_ch.point_x, want.point[0]);
				if (hit_ch.point_y !== want.point[1])
					report_mismatch("point_y", hit_ch.point_y, want.point[1]);
				if (hit_ch.point_z !== want.point[2])
					report_mismatch("point_z", hit_ch.point_z, want.point[2]);
				if (hit_ch.normal_x !== want.normal[0])
					report_mismatch("normal_x", hit_ch.normal_x, want.normal[0]);
				if (hit_ch.normal_y !== want.normal[1])
					report_mismatch("normal_y", hit_ch.normal_y, want.normal[1]);
				if (hit_ch.normal_z !== want.normal[2])
					report_mismatch("normal_z", hit_ch.normal_z, want.normal[2]);
			end
		end
	end

	task automatic send_ray(ray_beat_t r);
		while ($urandom_range(99) < send_idle) begin
			ray_ch.valid <= 1'b0;
			@(posedge clk);
		end
		ray_ch.valid <= 1'b1;
		ray_ch.origin_x <= r.o[0];
		ray_ch.origin_y <= r.o[1];
		ray_ch.origin_z <= r.o[2];
		ray_ch.dir_x <= r.d[0];
		ray_ch.dir_y <= r.d[1];
		ray_ch.dir_z <= r.d[2];
		do
			@(posedge clk);
		while (!ray_ch.ready);
		expected_hits.insert(expected_hits.size(), predict_hit(r));
	endtask

	task automatic wait_drained();
		ray_ch.valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic set_geometry(longint cx, longint cy, longint cz,
		longint kx, longint ky, longint kz);
		longint vals[6];
		vals = '{cx, cy, cz, kx, ky, kz};
		wait_drained();
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i][CW-1:0];
			@(posedge clk);
			if (i < 3)
				center[i] = longint'(coord_t'(vals[i][CW-1:0]));
			else
				inv_sq[i-3] = longint'(vals[i][KW-1:0]);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic ray_beat_t make_ray(longint ox, longint oy, longint oz,
		longint dx, longint dy, longint dz);
		ray_beat_t r;
		r.o[0] = coord_t'(ox);
		r.o[1] = coord_t'(oy);
		r.o[2] = coord_t'(oz);
		r.d[0] = coord_t'(dx);
		r.d[1] = coord_t'(dy);
		r.d[2] = coord_t'(dz);
		return r;
	endfunction

	function automatic ray_beat_t noise_ray();
		ray_beat_t r;
		for (int i = 0; i < 3; i++) begin
			r.o[i] = coord_t'($urandom);
			r.d[i] = coord_t'($urandom);
		end
		return r;
	endfunction

	function automatic ray_beat_t aimed_ray(int spread);
		ray_beat_t r;
		longint o, tgt, dv;
		int sh;
		sh = $urandom_range(4);
		for (int i = 0; i < 3; i++) begin
			o = center[i] + longint'($urandom_range(2 * spread)) - spread;
			tgt = center[i] + longint'($urandom_range(26000)) - 13000;
			dv = (tgt - o) >>> sh;
			if (dv == 0)
				dv = $urandom_range(1) ? 1 : -1;
			r.o[i] = coord_t'(o);
			r.d[i] = coord_t'(dv);
		end
		return r;
	endfunction

	task automatic test_reset_geometry();
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0));
		send_ray(make_ray(0, 0, 0, 0, ONE, 0));
		send_ray(make_ray(5 * ONE, 0, 0, ONE, 0, 0));
		send_ray(make_ray(-5 * ONE, 0, 0, 0, 0, 0));
		send_ray(make_ray(-5 * ONE, ONE, 0, ONE, 0, 0));
		send_ray(make_ray(-5 * ONE, 0, 0, 1, 0, 0));
		send_ray(make_ray(-5 * ONE, 0, 0, 256, 0, 0));
		send_ray(make_ray(0, 0, -3 * ONE, 0, 0, 2 * ONE));
		send_ray(make_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_ray(make_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_ray(make_ray(COORD_MIN, 0, 0, COORD_MAX, 0, 0));
		send_ray(make_ray(COORD_MAX, 0, 0, COORD_MIN, 0, 0));
		send_ray(make_ray(0, COORD_MIN, COORD_MAX, 0, ONE, -ONE));
		send_ray(make_ray(0, 0, 0, COORD_MIN, COORD_MAX, 1));
		send_ray(make_ray(ONE / 2, 0, 0, -ONE, 0, 0));
	endtask

	task automatic test_extreme_geometry();
		set_geometry(COORD_MAX, COORD_MIN, 0, longint'(DIST_MAX), 1, ONE);
		send_ray(make_ray(COORD_MAX, COORD_MIN, -5 * ONE, 0, 0, ONE));
		send_ray(make_ray(COORD_MAX - 2, COORD_MIN, 0, 1, 0, 0));
		send_ray(make_ray(0, 0, 0, COORD_MAX, COORD_MIN, COORD_MAX));
		send_ray(make_ray(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		set_geometry(COORD_MIN, COORD_MAX, COORD_MIN, 1, longint'(DIST_MAX), 1);
		send_ray(make_ray(COORD_MIN, COORD_MAX, COORD_MIN + ONE, 0, 0, ONE));
		send_ray(make_ray(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
		send_ray(make_ray(0, COORD_MAX - ONE, 0, 0, ONE, 0));
	endtask

	task automatic test_random_rounds();
		int pick;
		for (int round = 0; round < 6; round++) begin
			set_geometry(longint'($urandom_range(1310720)) - 655360,
				longint'($urandom_range(1310720)) - 655360,
				longint'($urandom_range(1310720)) - 655360,
				$urandom_range(1 << 20, 4096), $urandom_range(1 << 20, 4096),
				$urandom_range(1 << 20, 4096));
			unique case (round / 2)
				0: begin send_idle = 26; recv_idle = 79; end
				1: begin send_idle = 79; recv_idle = 26; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int n = 0; n < 155; n++) begin
				pick = $urandom_range(99);
				if (pick < 60)
					send_ray(aimed_ray(1966080));
				else if (pick < 72)
					send_ray(aimed_ray(20000));
				else if (pick < 85)
					send_ray(aimed_ray(200000000));
				else
					send_ray(noise_ray());
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 3; i++) begin
			center[i] = 0;
			inv_sq[i] = ONE;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_extreme_geometry();
		test_random_rounds();
		wait_drained();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
